/* sv/stack_with_middle_access_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the stack with middle access
// Clocked, reset-qualified property wrappers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef STACK_WITH_MIDDLE_ACCESS_ASSERT_SVH
`define STACK_WITH_MIDDLE_ACCESS_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset
`define SWMA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("stack_with_middle_access: assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset
`define SWMA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("stack_with_middle_access: assertion failed");

`endif

/* sv/swma_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack with middle access: shared definitions
// Depth, widths, command and status codes and the request/response types.
// ----------------------------------------------------------------------------
package swma_pkg;

  localparam int StackDepth  = 64;
  localparam int DataW       = 32;
  localparam int CntW        = $clog2(StackDepth + 1);
  localparam int CountFieldW = 7;

  typedef enum logic [1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_DELMID = 2'd2,
    CMD_REPORT = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e                    cmd;
    logic signed [DataW-1:0] push_value;
  } req_t;

  typedef struct packed {
    logic signed [DataW-1:0] removed_value;
    logic signed [DataW-1:0] middle_value;
    logic [CountFieldW-1:0]  entry_count;
    status_e                 status;
  } rsp_t;

  // Per-cell control: take the entry from above, or from below
  typedef struct packed {
    logic push;
    logic shift;
  } cell_ctrl_t;

endpackage

/* sv/swma_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack cell
// Holds one entry; loads from the neighbour above on push, from the
// neighbour below when an entry at or above it is removed.
// ----------------------------------------------------------------------------
module swma_cell (
  input  logic                              clk_i,
  input  swma_pkg::cell_ctrl_t              ctrl_i,
  input  logic signed [swma_pkg::DataW-1:0] above_i,
  input  logic signed [swma_pkg::DataW-1:0] below_i,
  input  logic                              tap_en_i,
  output logic signed [swma_pkg::DataW-1:0] data_o,
  output logic signed [swma_pkg::DataW-1:0] tap_o
);
  import swma_pkg::*;

  logic signed [DataW-1:0] data_d, data_q;

  // Choose the next entry: push moves down, removal closes the gap upwards
  always_comb begin
    data_d = data_q;
    if (ctrl_i.push) begin
      data_d = above_i;
    end else if (ctrl_i.shift) begin
      data_d = below_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

  // Drive the entry onto the middle tap only when selected
  assign tap_o = tap_en_i ? data_q : '0;

endmodule

/* sv/stack_with_middle_access.sv */
`timescale 1ns / 1ps
// Sequencing: an accepted request moves the controller to the middle state,
// which registers the result once no earlier result is held; a new request
// is taken only back in idle. The cell row updates at the accepting edge
// and the middle entry is selected from it in the next cycle.
// Reset clears the entry count, the controller and the output valid;
// cell contents stay undefined until pushed and are never read before then.
// ----------------------------------------------------------------------------
// Stack with middle access
// Bounded stack held in a row of cells with the top at cell 0; push, pop,
// delete-middle and report requests, each answered with one response.
// ----------------------------------------------------------------------------
module stack_with_middle_access (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  swma_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output swma_pkg::rsp_t out_rsp_o
);
  import swma_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_MID  = 2'b10
  } state_e;

  state_e                  state_d, state_q;
  logic [CntW-1:0]         count_d, count_q;
  logic signed [DataW-1:0] removed_d, removed_q;
  status_e                 status_d, status_q;
  logic                    out_valid_d, out_valid_q;
  rsp_t                    rsp_d, rsp_q;

  logic                    accept;
  logic                    is_empty, is_full;
  logic                    push_en, remove_en;
  logic [CntW-1:0]         remove_pos;
  logic [CntW-1:0]         mid_pos;
  logic signed [DataW-1:0] mid_value;

  cell_ctrl_t              ctrl    [StackDepth];
  logic                    tap_en  [StackDepth];
  logic signed [DataW-1:0] cell_q  [StackDepth];
  logic signed [DataW-1:0] taps    [StackDepth];

  assign accept   = in_valid_i && in_ready_o;
  assign is_empty = (count_q == '0);
  assign is_full  = (count_q == CntW'(StackDepth));
  assign mid_pos  = count_q >> 1;

  // Decode the request into cell controls, count and partial response
  always_comb begin
    push_en    = 1'b0;
    remove_en  = 1'b0;
    remove_pos = '0;
    count_d    = count_q;
    removed_d  = removed_q;
    status_d   = status_q;
    if (accept) begin
      removed_d = '0;
      status_d  = STS_OK;
      unique case (in_req_i.cmd)
        CMD_PUSH: begin
          if (is_full) begin
            status_d = STS_FULL;
          end else begin
            push_en = 1'b1;
            count_d = count_q + 1'b1;
          end
        end
        CMD_POP: begin
          if (is_empty) begin
            status_d = STS_EMPTY;
          end else begin
            remove_en = 1'b1;
            removed_d = cell_q[0];
            count_d   = count_q - 1'b1;
          end
        end
        CMD_DELMID: begin
          if (is_empty) begin
            status_d = STS_EMPTY;
          end else begin
            remove_en  = 1'b1;
            remove_pos = mid_pos;
            removed_d  = mid_value;
            count_d    = count_q - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Row of cells, top of stack at index 0
  for (genvar k = 0; k < StackDepth; k++) begin : g_cell
    logic signed [DataW-1:0] above, below;

    assign ctrl[k].push  = push_en;
    assign ctrl[k].shift = remove_en && (CntW'(k) >= remove_pos);
    assign tap_en[k]     = !is_empty && (CntW'(k) == mid_pos);

    if (k == 0) begin : g_top
      assign above = in_req_i.push_value;
    end else begin : g_inner
      assign above = cell_q[k-1];
    end

    if (k == StackDepth - 1) begin : g_bottom
      assign below = '0;
    end else begin : g_rest
      assign below = cell_q[k+1];
    end

    swma_cell u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl[k]),
      .above_i  (above),
      .below_i  (below),
      .tap_en_i (tap_en[k]),
      .data_o   (cell_q[k]),
      .tap_o    (taps[k])
    );
  end

  // Merge the one-hot middle taps
  always_comb begin
    mid_value = '0;
    for (int k = 0; k < StackDepth; k++) begin
      mid_value = mid_value | taps[k];
    end
  end

  // Sequence the request and hold the response until taken
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    rsp_d       = rsp_q;
    in_ready_o  = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ST_MID;
        end
      end
      ST_MID: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d         = 1'b1;
          rsp_d.removed_value = removed_q;
          rsp_d.middle_value  = mid_value;
          rsp_d.entry_count   = CountFieldW'(count_q);
          rsp_d.status        = status_q;
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    removed_q <= removed_d;
    status_q  <= status_d;
    rsp_q     <= rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

/* sv/swma_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack with middle access: port checker
// Watches the top-level ports for response consistency and request pacing.
// ----------------------------------------------------------------------------
`include "stack_with_middle_access_assert.svh"

module swma_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input swma_pkg::rsp_t out_rsp_o
);
  import swma_pkg::*;

  // Stalled response holds
  `SWMA_ASSERT_NEXT(a_rsp_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_rsp_o))

  // An accepted request blocks the next one for the following cycle
  `SWMA_ASSERT_NEXT(a_req_pacing, in_valid_i && in_ready_o, !in_ready_o)

  // Failed requests report no removed value
  `SWMA_ASSERT_NOW(a_fail_no_removed, out_valid_o && (out_rsp_o.status != STS_OK), out_rsp_o.removed_value == '0)

  // An empty stack reports a zero middle, and an empty status an empty stack
  `SWMA_ASSERT_NOW(a_empty_middle, out_valid_o && ((out_rsp_o.entry_count == '0) || (out_rsp_o.status == STS_EMPTY)), (out_rsp_o.middle_value == '0) && (out_rsp_o.entry_count == '0))

endmodule

bind stack_with_middle_access swma_checker u_swma_checker (.*);
